FILE: design/csp_pkg.sv
// Shared constants, register codes and controller/datapath link types for crop_sum_pool.
// No dependencies; every other design file except csp_ram refers to it by scoped names.
package csp_pkg;

   // sizing
   localparam int MaxOutCols  = 256;
   localparam int ValueBits   = 16;
   localparam int TickBits    = 14;
   localparam int WireBits    = 12;
   localparam int PoolBits    = 7;
   localparam int OutSizeBits = 9;
   localparam int OutIdxBits  = 8;
   localparam int SumBits     = 32;
   localparam int SpanBits    = PoolBits + OutSizeBits;
   localparam int MaxOutRows  = 256;
   localparam int MemAddrBits = (MaxOutCols > 1) ? $clog2(MaxOutCols) : 1;

   // divider runs over the wider of the two offsets
   localparam int DivBits     = (TickBits > WireBits) ? TickBits : WireBits;
   localparam int DivSteps    = DivBits;
   localparam int StepBits    = (DivSteps > 1) ? $clog2(DivSteps) : 1;

   // configuration port
   localparam int CsrIdxBits  = 3;
   localparam int CsrDataBits = TickBits;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_TICK_START = 3'd0,
      CSR_WIRE_START = 3'd1,
      CSR_POOL_ROWS  = 3'd2,
      CSR_POOL_COLS  = 3'd3,
      CSR_OUT_ROWS   = 3'd4,
      CSR_OUT_COLS   = 3'd5
   } csr_idx_type;

   localparam logic [PoolBits-1:0]    PoolRowsReset = PoolBits'(1);
   localparam logic [PoolBits-1:0]    PoolColsReset = PoolBits'(1);
   localparam logic [OutSizeBits-1:0] OutRowsReset  = OutSizeBits'(247);
   localparam logic [OutSizeBits-1:0] OutColsReset  = OutSizeBits'(247);

   // controller to datapath
   typedef struct packed {
      logic latch;      // capture the incoming word
      logic load_div;   // window check cycle, seed the dividers
      logic div_step;   // one quotient bit
      logic rd_en;      // fetch the column accumulator
      logic commit;     // update accumulator, emit when block is done
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_window;
      logic last;
      logic out_free;
   } status_type;

endpackage

FILE: design/csp_if.sv
// Valid/ready channel interfaces for the pixel input and pooled result output.
// Depends on csp_pkg for field widths.
interface csp_req_if;
   logic                                valid;
   logic                                ready;
   logic [csp_pkg::TickBits-1:0]        tick_index;
   logic [csp_pkg::WireBits-1:0]        wire_index;
   logic signed [csp_pkg::ValueBits-1:0] pixel_value;

   modport source (output valid, tick_index, wire_index, pixel_value, input ready);
   modport sink   (input valid, tick_index, wire_index, pixel_value, output ready);
endinterface

interface csp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [csp_pkg::OutIdxBits-1:0]      out_row;
   logic [csp_pkg::OutIdxBits-1:0]      out_col;
   logic signed [csp_pkg::SumBits-1:0]  pooled_sum;

   modport source (output valid, out_row, out_col, pooled_sum, input ready);
   modport sink   (input valid, out_row, out_col, pooled_sum, output ready);
endinterface

FILE: design/csp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csp_ram #(
   parameter int Width = 32,
   parameter int Depth = 256,
   localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AddrBits-1:0]    wr_addr,
   input  logic [Width-1:0]       wr_data,
   input  logic                   rd_en,
   input  logic [AddrBits-1:0]    rd_addr,
   output logic [Width-1:0]       rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/csp_ctrl.sv
// Sequencer for crop_sum_pool: accept, window check, divide, read, update/emit.
// Depends on csp_pkg for the command and status structs.
module csp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  csp_pkg::status_type stat,
   output csp_pkg::cmd_type    cmd
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_READ  = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [csp_pkg::StepBits-1:0]  step_ff, step_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.load_div = 1'b1;
            step_in      = '0;
            state_in     = stat.in_window ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == csp_pkg::StepBits'(csp_pkg::DivSteps - 1)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            // hold while a finished block waits for room in the output register
            if (!stat.last || stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end
endmodule

FILE: design/csp_dp.sv
// Datapath for crop_sum_pool: config registers, window check, two restoring
// dividers, column accumulator RAM with valid bits, output register. Uses csp_pkg, csp_ram.
module csp_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  csp_pkg::cmd_type                    cmd,
   output csp_pkg::status_type                 stat,
   input  logic                                csr_write_en,
   input  logic [csp_pkg::CsrIdxBits-1:0]      csr_index,
   input  logic [csp_pkg::CsrDataBits-1:0]     csr_wdata,
   input  logic [csp_pkg::TickBits-1:0]        tick_index,
   input  logic [csp_pkg::WireBits-1:0]        wire_index,
   input  logic signed [csp_pkg::ValueBits-1:0] pixel_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [csp_pkg::OutIdxBits-1:0]      out_row,
   output logic [csp_pkg::OutIdxBits-1:0]      out_col,
   output logic signed [csp_pkg::SumBits-1:0]  pooled_sum
);
   localparam int TB = csp_pkg::TickBits;
   localparam int WB = csp_pkg::WireBits;
   localparam int PB = csp_pkg::PoolBits;
   localparam int OB = csp_pkg::OutSizeBits;
   localparam int SB = csp_pkg::SpanBits;
   localparam int DB = csp_pkg::DivBits;
   localparam int AB = csp_pkg::MemAddrBits;
   localparam int XB = csp_pkg::SumBits;
   localparam int IB = csp_pkg::OutIdxBits;

   // configuration
   logic [TB-1:0] tick_start_ff;
   logic [WB-1:0] wire_start_ff;
   logic [PB-1:0] pool_rows_ff, pool_cols_ff;
   logic [OB-1:0] out_rows_ff, out_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_start_ff <= '0;
         wire_start_ff <= '0;
         pool_rows_ff  <= csp_pkg::PoolRowsReset;
         pool_cols_ff  <= csp_pkg::PoolColsReset;
         out_rows_ff   <= csp_pkg::OutRowsReset;
         out_cols_ff   <= csp_pkg::OutColsReset;
      end else if (csr_write_en) begin
         unique case (csr_index)
            csp_pkg::CSR_TICK_START: tick_start_ff <= csr_wdata[TB-1:0];
            csp_pkg::CSR_WIRE_START: wire_start_ff <= csr_wdata[WB-1:0];
            csp_pkg::CSR_POOL_ROWS:  pool_rows_ff  <= csr_wdata[PB-1:0];
            csp_pkg::CSR_POOL_COLS:  pool_cols_ff  <= csr_wdata[PB-1:0];
            csp_pkg::CSR_OUT_ROWS:   out_rows_ff   <= csr_wdata[OB-1:0];
            csp_pkg::CSR_OUT_COLS:   out_cols_ff   <= csr_wdata[OB-1:0];
            default: ;
         endcase
      end
   end

   // capture the incoming word
   logic [TB-1:0]        tick_ff;
   logic [WB-1:0]        wire_ff;
   logic signed [csp_pkg::ValueBits-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         tick_ff  <= tick_index;
         wire_ff  <= wire_index;
         value_ff <= pixel_value;
      end
   end

   // window check: offsets against the saturated spans
   logic [OB-1:0] rows_sat, cols_sat;
   logic [SB-1:0] span_t, span_w;
   logic [TB-1:0] dt;
   logic [WB-1:0] dw;
   logic          in_window;

   always_comb begin
      rows_sat = (int'(out_rows_ff) > csp_pkg::MaxOutRows) ?
                 OB'(csp_pkg::MaxOutRows) : out_rows_ff;
      cols_sat = (int'(out_cols_ff) > csp_pkg::MaxOutCols) ?
                 OB'(csp_pkg::MaxOutCols) : out_cols_ff;
      span_t   = SB'(pool_rows_ff) * SB'(rows_sat);
      span_w   = SB'(pool_cols_ff) * SB'(cols_sat);
      dt       = tick_ff - tick_start_ff;
      dw       = wire_ff - wire_start_ff;
      in_window = (span_t != '0) && (span_w != '0) &&
                  (tick_ff >= tick_start_ff) && (wire_ff >= wire_start_ff) &&
                  (SB'(dt) < span_t) && (SB'(dw) < span_w);
   end

   // restoring dividers: quotient shifts in where the dividend shifts out
   logic [DB-1:0] q_t_ff, q_t_in, q_w_ff, q_w_in;
   logic [PB-1:0] r_t_ff, r_t_in, r_w_ff, r_w_in;
   logic [PB:0]   sh_t, sh_w;

   always_comb begin
      sh_t   = {r_t_ff, q_t_ff[DB-1]};
      sh_w   = {r_w_ff, q_w_ff[DB-1]};
      q_t_in = q_t_ff;
      q_w_in = q_w_ff;
      r_t_in = r_t_ff;
      r_w_in = r_w_ff;
      if (cmd.load_div) begin
         q_t_in = DB'(dt);
         q_w_in = DB'(dw);
         r_t_in = '0;
         r_w_in = '0;
      end else if (cmd.div_step) begin
         if (sh_t >= {1'b0, pool_rows_ff}) begin
            r_t_in = PB'(sh_t - {1'b0, pool_rows_ff});
            q_t_in = {q_t_ff[DB-2:0], 1'b1};
         end else begin
            r_t_in = sh_t[PB-1:0];
            q_t_in = {q_t_ff[DB-2:0], 1'b0};
         end
         if (sh_w >= {1'b0, pool_cols_ff}) begin
            r_w_in = PB'(sh_w - {1'b0, pool_cols_ff});
            q_w_in = {q_w_ff[DB-2:0], 1'b1};
         end else begin
            r_w_in = sh_w[PB-1:0];
            q_w_in = {q_w_ff[DB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      q_t_ff <= q_t_in;
      q_w_ff <= q_w_in;
      r_t_ff <= r_t_in;
      r_w_ff <= r_w_in;
   end

   // column accumulators; an entry without its valid bit reads as zero
   logic [AB-1:0]         col_addr;
   logic [XB-1:0]         rd_data, base, sum;
   logic [csp_pkg::MaxOutCols-1:0] valid_ff;
   logic                  last_blk;
   logic                  out_free;

   assign col_addr  = q_w_ff[AB-1:0];
   assign last_blk  = (r_t_ff == pool_rows_ff - 1'b1) && (r_w_ff == pool_cols_ff - 1'b1);
   assign base      = valid_ff[col_addr] ? rd_data : '0;
   assign sum       = base + XB'(value_ff);

   csp_ram #(
      .Width (XB),
      .Depth (csp_pkg::MaxOutCols)
   ) u_sums (
      .clock   (clock),
      .wr_en   (cmd.commit && !last_blk),
      .wr_addr (col_addr),
      .wr_data (sum),
      .rd_en   (cmd.rd_en),
      .rd_addr (col_addr),
      .rd_data (rd_data)
   );

   // a finished block clears its entry by dropping the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff[col_addr] <= !last_blk;
      end
   end

   // output register
   logic              rsp_valid_ff;
   logic [IB-1:0]     out_row_ff, out_col_ff;
   logic [XB-1:0]     sum_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // report status to the controller
   assign stat = '{in_window: in_window, last: last_blk, out_free: out_free};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && last_blk) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && last_blk) begin
         out_row_ff <= q_t_ff[IB-1:0];
         out_col_ff <= q_w_ff[IB-1:0];
         sum_ff     <= sum;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign out_row    = out_row_ff;
   assign out_col    = out_col_ff;
   assign pooled_sum = sum_ff;
endmodule

FILE: design/crop_sum_pool.sv
// Top level of the crop-and-sum-pooling downsampler: controller, datapath, channel glue.
// Depends on csp_pkg, csp_if, csp_ctrl, csp_dp (and csp_ram below it).
//
//   channel   direction  handshake              word
//   req_port  in         valid/ready            tick_index, wire_index, pixel_value
//   rsp_port  out        valid/ready            out_row, out_col, pooled_sum
//   csr_*     in         csr_write_en, no wait  csr_index, csr_wdata
//
// A pixel inside the crop window passes from acceptance to the next acceptance
// through the window check, the bit-serial divider steps (one per quotient bit),
// the accumulator RAM read, the update and the idle state that takes the
// next word. A pixel outside the window passes only the check and the idle state.
// The update cycle holds while a finished block waits for the output register.
// Reset is synchronous; accumulators read as zero after reset through per-column
// valid bits, so no clearing pass is needed.
module crop_sum_pool (
   input  logic                              clock,
   input  logic                              reset,
   csp_req_if.sink                           req_port,
   csp_rsp_if.source                         rsp_port,
   input  logic                              csr_write_en,
   input  logic [csp_pkg::CsrIdxBits-1:0]    csr_index,
   input  logic [csp_pkg::CsrDataBits-1:0]   csr_wdata
);
   csp_pkg::cmd_type    cmd;
   csp_pkg::status_type stat;
   logic                req_ready;

   csp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   csp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .tick_index   (req_port.tick_index),
      .wire_index   (req_port.wire_index),
      .pixel_value  (req_port.pixel_value),
      .rsp_valid    (rsp_port.valid),
      .rsp_ready    (rsp_port.ready),
      .out_row      (rsp_port.out_row),
      .out_col      (rsp_port.out_col),
      .pooled_sum   (rsp_port.pooled_sum)
   );

   assign req_port.ready = req_ready;

   // never emit into an occupied output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && stat.last && !stat.out_free))
      else $error("pooled word emitted while output register busy");

   // one word at a time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_ready |=> !req_ready)
      else $error("input accepted back to back");

   // a pixel outside the window returns straight to idle
   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_div && !stat.in_window |=> req_ready)
      else $error("dropped pixel did not release the input");
endmodule

FILE: verif/crop_sum_pool_test.sv
// Testbench for crop_sum_pool: feeds raster scans of raw pixels through the crop window
// and checks every pooled word against an accumulator model kept in the bench.
// Depends on csp_pkg, csp_if (csp_req_if, csp_rsp_if) and the crop_sum_pool design files.
`timescale 1ns / 100ps

module crop_sum_pool_test;

   // sizes taken from the design package
   localparam int CsrIdxBits  = csp_pkg::CsrIdxBits;
   localparam int CsrDataBits = csp_pkg::CsrDataBits;
   localparam int TickBits    = csp_pkg::TickBits;
   localparam int WireBits    = csp_pkg::WireBits;
   localparam int ValueBits   = csp_pkg::ValueBits;
   localparam int OutIdxBits  = csp_pkg::OutIdxBits;
   localparam int SumBits     = csp_pkg::SumBits;
   localparam int PoolBits    = csp_pkg::PoolBits;
   localparam int OutSizeBits = csp_pkg::OutSizeBits;
   localparam int MaxOutCols  = csp_pkg::MaxOutCols;
   localparam int MaxOutRows  = csp_pkg::MaxOutRows;

   // indexes that decode to no register
   localparam logic [CsrIdxBits-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CsrIdxBits-1:0] CSR_SPARE_B = 3'd7;

   localparam int RandomItems  = 700;
   localparam int SettleCycles = 40;
   localparam int TickMax      = (1 << TickBits) - 1;
   localparam int WireMax      = (1 << WireBits) - 1;

   typedef struct packed {
      logic [TickBits-1:0]         tick_idx;
      logic [WireBits-1:0]         wire_idx;
      logic signed [ValueBits-1:0] value;
   } pixel_type;

   typedef struct packed {
      logic [OutIdxBits-1:0]     row;
      logic [OutIdxBits-1:0]     col;
      logic signed [SumBits-1:0] total;
   } pooled_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CsrIdxBits-1:0]  csr_index;
   logic [CsrDataBits-1:0] csr_wdata;

   csp_req_if pixel_ch ();
   csp_rsp_if pooled_ch ();

   crop_sum_pool DUT (
      .clock        (clock),
      .reset        (reset),
      .req_port     (pixel_ch),
      .rsp_port     (pooled_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // bench copy of the window registers and the column accumulators
   logic [TickBits-1:0]    win_tick0;
   logic [WireBits-1:0]    win_wire0;
   logic [PoolBits-1:0]    pool_h;
   logic [PoolBits-1:0]    pool_w;
   logic [OutSizeBits-1:0] out_h;
   logic [OutSizeBits-1:0] out_w;
   logic [SumBits-1:0]     col_acc [MaxOutCols] = '{default: '0};

   pixel_type   pixel_backlog [$];
   pooled_type  due_blocks [$];
   pixel_type   next_px;
   pooled_type  got_blk;
   pooled_type  want_blk;
   int unsigned queued;
   int unsigned accepted;
   int unsigned checked;
   int unsigned errors;
   int unsigned phases;
   int unsigned cycle_count;
   bit          quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("%t timeout: %0d pooled words still due", $time, due_blocks.size());
      $display("simulation failed");
      $finish;
   end

   // one stretch in three with no idling on either side
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      quiet       <= ((cycle_count / 1500) % 3) == 2;
   end

   function automatic bit take_break();
      return !quiet && ($urandom_range(0, 99) < 8);
   endfunction

   // Add one pixel to its column and queue the pooled word when the block closes.
   function automatic void fold_pixel(input pixel_type px);
      int unsigned rows, cols, span_t, span_w, dt, dw, orow, ocol;
      pooled_type  blk;
      rows   = (out_h > MaxOutRows) ? MaxOutRows : out_h;
      cols   = (out_w > MaxOutCols) ? MaxOutCols : out_w;
      span_t = pool_h * rows;
      span_w = pool_w * cols;
      if (span_t == 0 || span_w == 0) return;
      if (px.tick_idx < win_tick0 || px.wire_idx < win_wire0) return;
      dt = px.tick_idx - win_tick0;
      dw = px.wire_idx - win_wire0;
      if (dt >= span_t || dw >= span_w) return;
      orow = dt / pool_h;
      ocol = dw / pool_w;
      if (ocol >= MaxOutCols) return;
      col_acc[ocol] = col_acc[ocol] + {{(SumBits-ValueBits){px.value[ValueBits-1]}}, px.value};
      if ((dt % pool_h) == pool_h - 1 && (dw % pool_w) == pool_w - 1) begin
         blk.row   = orow[OutIdxBits-1:0];
         blk.col   = ocol[OutIdxBits-1:0];
         blk.total = col_acc[ocol];
         due_blocks.insert(due_blocks.size(), blk);
         col_acc[ocol] = '0;
      end
   endfunction

   // Pixel driver: fold each accepted word, then offer the next one unless idling.
   always @(posedge clock) begin
      if (reset) begin
         pixel_ch.valid <= 1'b0;
      end else begin
         if (pixel_ch.valid && pixel_ch.ready) begin
            fold_pixel({pixel_ch.tick_index, pixel_ch.wire_index, pixel_ch.pixel_value});
            accepted++;
         end
         if (!pixel_ch.valid || pixel_ch.ready) begin
            if (pixel_backlog.size() != 0 && !take_break()) begin
               next_px                 = pixel_backlog.pop_front();
               pixel_ch.valid         <= 1'b1;
               pixel_ch.tick_index    <= next_px.tick_idx;
               pixel_ch.wire_index    <= next_px.wire_idx;
               pixel_ch.pixel_value   <= next_px.value;
            end else begin
               pixel_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: match each pooled word with the oldest one due.
   always @(posedge clock) begin
      if (reset) begin
         pooled_ch.ready <= 1'b0;
      end else begin
         if (pooled_ch.valid && pooled_ch.ready) begin
            got_blk = {pooled_ch.out_row, pooled_ch.out_col, pooled_ch.pooled_sum};
            checked++;
            if (due_blocks.size() == 0) begin
               $display("%t unexpected word: expected none, got row %0d col %0d sum %0d",
                        $time, got_blk.row, got_blk.col, got_blk.total);
               errors++;
            end else begin
               want_blk = due_blocks.pop_front();
               if (got_blk.row !== want_blk.row) begin
                  $display("%t out_row: expected %0d, got %0d", $time, want_blk.row, got_blk.row);
                  errors++;
               end
               if (got_blk.col !== want_blk.col) begin
                  $display("%t out_col: expected %0d, got %0d", $time, want_blk.col, got_blk.col);
                  errors++;
               end
               if (got_blk.total !== want_blk.total) begin
                  $display("%t pooled_sum: expected %0d, got %0d",
                           $time, want_blk.total, got_blk.total);
                  errors++;
               end
            end
         end
         pooled_ch.ready <= !take_break();
      end
   end

   // Register writes: the block is idle, so the bench copy is updated right away.
   task automatic write_reg(input logic [CsrIdxBits-1:0] idx, input int unsigned data);
      logic [CsrDataBits-1:0] bus;
      bus = data[CsrDataBits-1:0];
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= bus;
      case (idx)
         csp_pkg::CSR_TICK_START: win_tick0 = bus[TickBits-1:0];
         csp_pkg::CSR_WIRE_START: win_wire0 = bus[WireBits-1:0];
         csp_pkg::CSR_POOL_ROWS:  pool_h    = bus[PoolBits-1:0];
         csp_pkg::CSR_POOL_COLS:  pool_w    = bus[PoolBits-1:0];
         csp_pkg::CSR_OUT_ROWS:   out_h     = bus[OutSizeBits-1:0];
         csp_pkg::CSR_OUT_COLS:   out_w     = bus[OutSizeBits-1:0];
         default: ;
      endcase
   endtask

   task automatic close_writes();
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // set bits above the register width now and then; they must be dropped
   function automatic int unsigned with_junk(input int unsigned v, input int w);
      if ($urandom_range(0, 3) == 0) return v | ($urandom << w);
      return v;
   endfunction

   task automatic set_window(input int unsigned ts, input int unsigned ws,
                             input int unsigned ph, input int unsigned pw,
                             input int unsigned oh, input int unsigned ow);
      write_reg(csp_pkg::CSR_TICK_START, ts);
      write_reg(csp_pkg::CSR_WIRE_START, with_junk(ws, WireBits));
      write_reg(csp_pkg::CSR_POOL_ROWS,  with_junk(ph, PoolBits));
      write_reg(csp_pkg::CSR_POOL_COLS,  with_junk(pw, PoolBits));
      write_reg(csp_pkg::CSR_OUT_ROWS,   with_junk(oh, OutSizeBits));
      write_reg(csp_pkg::CSR_OUT_COLS,   with_junk(ow, OutSizeBits));
      if ($urandom_range(0, 3) == 0)
         write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, $urandom);
      close_writes();
      phases++;
   endtask

   function automatic void queue_pixel(input int unsigned t, input int unsigned w,
                                       input logic signed [ValueBits-1:0] v);
      pixel_type px;
      px.tick_idx = t[TickBits-1:0];
      px.wire_idx = w[WireBits-1:0];
      px.value    = v;
      pixel_backlog.insert(pixel_backlog.size(), px);
      queued++;
   endfunction

   function automatic logic signed [ValueBits-1:0] pick_value();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, 1) ? {1'b0, {(ValueBits-1){1'b1}}}
                                     : {1'b1, {(ValueBits-1){1'b0}}};
      return ValueBits'($urandom);
   endfunction

   // Wait until every word is accepted and answered, then let the block go quiet.
   task automatic settle();
      while (accepted != queued || due_blocks.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Raster scan from the window corner with random noise, strays and repeats mixed in.
   task automatic queue_scan(input int n_rows, input int n_cols, input bit lead);
      int        t0, w0, t, w, roll;
      pixel_type prev;
      bit        have_prev;
      have_prev = 1'b0;
      t0 = int'(win_tick0) - ((lead && win_tick0 != 0) ? 1 : 0);
      w0 = int'(win_wire0) - ((lead && win_wire0 != 0) ? 1 : 0);
      for (int r = 0; r < n_rows; r++) begin
         for (int c = 0; c < n_cols; c++) begin
            t = t0 + r;
            w = w0 + c;
            if (t > TickMax || w > WireMax) continue;
            roll = $urandom_range(0, 99);
            if (roll < 6)
               queue_pixel($urandom_range(0, TickMax), $urandom_range(0, WireMax),
                           ValueBits'($urandom));
            else if (roll < 9)
               queue_pixel($urandom_range(t0, t), $urandom_range(w0, w0 + n_cols - 1),
                           pick_value());
            else if (roll < 11 && have_prev)
               queue_pixel(int'(prev.tick_idx), int'(prev.wire_idx), pick_value());
            prev.tick_idx = t[TickBits-1:0];
            prev.wire_idx = w[WireBits-1:0];
            prev.value    = pick_value();
            have_prev     = 1'b1;
            queue_pixel(t, w, prev.value);
         end
      end
   endtask

   function automatic int unsigned pick_pool();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return $urandom_range(1, 3);
      if (roll < 90) return $urandom_range(4, 8);
      if (roll < 97) return $urandom_range(9, 16);
      return 0;
   endfunction

   function automatic int unsigned pick_out_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return $urandom_range(1, 6);
      if (roll < 97) return $urandom_range(MaxOutCols, (1 << OutSizeBits) - 1);
      return 0;
   endfunction

   function automatic int unsigned pick_start(input int unsigned hi, input int unsigned field_max);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 20);
      if (roll < 90) return $urandom_range(0, field_max);
      return $urandom_range(0, 1) ? hi : field_max;
   endfunction

   initial begin : stimulus
      int unsigned base, random_items;
      int          k_r, k_c, n_rows, n_cols;
      bit          open;
      reset        = 1'b1;
      csr_write_en = 1'b0;
      csr_index    = csp_pkg::CSR_TICK_START;
      csr_wdata    = '0;
      win_tick0 = '0;
      win_wire0 = '0;
      pool_h    = csp_pkg::PoolRowsReset;
      pool_w    = csp_pkg::PoolColsReset;
      out_h     = csp_pkg::OutRowsReset;
      out_w     = csp_pkg::OutColsReset;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 1x1 pooling, 247x247 window at the origin
      queue_pixel(0, 0, 16'sh8000);
      queue_pixel(0, 1, 16'sh7FFF);
      queue_pixel(246, 246, 16'sd1);
      queue_pixel(247, 0, 16'sd5);
      queue_pixel(0, 247, 16'sd5);
      queue_pixel(TickMax, WireMax, -16'sd1);
      queue_pixel(5, 5, 16'sh5555);
      queue_pixel(5, 5, 16'shAAAA);
      settle();

      // zero pooling factor closes the window
      write_reg(csp_pkg::CSR_POOL_ROWS, 0);
      close_writes();
      queue_pixel(0, 0, 16'sd7);
      settle();

      // far corner, oversized outputs saturate; spare indexes must not land anywhere
      write_reg(csp_pkg::CSR_TICK_START, 9600);
      write_reg(csp_pkg::CSR_WIRE_START, 3455);
      write_reg(csp_pkg::CSR_POOL_ROWS, 2);
      write_reg(csp_pkg::CSR_POOL_COLS, 1);
      write_reg(csp_pkg::CSR_OUT_ROWS, (1 << OutSizeBits) - 1);
      write_reg(csp_pkg::CSR_OUT_COLS, 300);
      write_reg(CSR_SPARE_A, 3);
      write_reg(CSR_SPARE_B, TickMax);
      close_writes();
      queue_pixel(9600 + 511, 3455 + 255, 16'sd100);
      queue_pixel(9600, 3455, 16'sh7FFF);
      queue_pixel(9601, 3455, 16'sh7FFF);
      queue_pixel(9599, 3455, 16'sd1);
      queue_pixel(9600, 3454, 16'sd1);
      queue_pixel(TickMax, WireMax, 16'sh1234);
      queue_pixel(9601, 3456, -16'sd5);
      settle();

      // zero output width, then a window pinned to the last tick
      write_reg(csp_pkg::CSR_OUT_COLS, 0);
      close_writes();
      queue_pixel(9600, 3455, 16'sd9);
      settle();
      write_reg(csp_pkg::CSR_TICK_START, TickMax);
      write_reg(csp_pkg::CSR_OUT_COLS, MaxOutCols);
      write_reg(csp_pkg::CSR_POOL_ROWS, 1);
      close_writes();
      queue_pixel(TickMax, 3455, 16'sd42);
      settle();
      phases = 5;

      // widest pooling factors, one block each way
      set_window(0, 0, (1 << PoolBits) - 1, 1, 1, 2);
      queue_scan((1 << PoolBits), 3, 1'b0);
      settle();
      set_window(0, 0, 1, (1 << PoolBits) - 1, 1, 1);
      queue_scan(2, (1 << PoolBits), 1'b0);
      settle();

      // random settings, each followed by a scan sized to close a few blocks
      random_items = 0;
      while (random_items < RandomItems) begin
         set_window(pick_start(9600, TickMax), pick_start(3455, WireMax),
                    pick_pool(), pick_pool(), pick_out_size(), pick_out_size());
         k_r = $urandom_range(1, 3);
         k_c = $urandom_range(1, 3);
         while ((pool_h * k_r + 1) * (pool_w * k_c + 1) > 400 && (k_r > 1 || k_c > 1)) begin
            if (k_r >= k_c) k_r--;
            else k_c--;
         end
         n_rows = (pool_h == 0) ? $urandom_range(1, 4) : pool_h * k_r + $urandom_range(0, 1);
         n_cols = (pool_w == 0) ? $urandom_range(1, 4) : pool_w * k_c + $urandom_range(0, 1);
         open = pool_h != 0 && pool_w != 0 && out_h != 0 && out_w != 0;
         base = queued;
         queue_scan(n_rows, n_cols, $urandom_range(0, 3) == 0);
         if (open) random_items += queued - base;
         settle();
      end

      $display("covered %0d pixel words over %0d register settings, %0d pooled words checked",
               accepted, phases, checked);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
